>>> rtl/core/rc5_block_cipher_macros.svh
// Assertion macros for the RC5 block cipher RTL.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef RC5_BLOCK_CIPHER_MACROS_SVH
`define RC5_BLOCK_CIPHER_MACROS_SVH

`define RC5_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define RC5_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/rc5_pkg.sv
// Shared constants, payload type and rotate helpers for the RC5 block cipher.
// No dependencies; used by every module in rtl/core.
`default_nettype none

package rc5_pkg;

	localparam int          RC5_ROUNDS    = 12;
	localparam int          RC5_KEY_WORDS = 4;
	localparam int          RC5_APB_AW    = 4;
	localparam logic [31:0] MAGIC_P       = 32'hB7E15163;
	localparam logic [31:0] MAGIC_Q       = 32'h9E3779B9;
	localparam logic [4:0]  MIX_ROT       = 5'd3;

	localparam logic [1:0] MODE_ENC    = 2'd0;
	localparam logic [1:0] MODE_DEC    = 2'd1;
	localparam logic [1:0] MODE_EXPAND = 2'd2;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic        last;
		logic        dec;
		logic        zero;
	} pld_t;

	function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] n);
		logic [63:0] t;
		t = {v, v} << n;
		return t[63:32];
	endfunction

	function automatic logic [31:0] rotr32(input logic [31:0] v, input logic [4:0] n);
		logic [63:0] t;
		t = {v, v} >> n;
		return t[31:0];
	endfunction

	function automatic logic [31:0] magic_init(input int k);
		return MAGIC_P + 32'(k) * MAGIC_Q;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/rc5_round.sv
// One RC5 round as a pipeline stage: encrypt or decrypt half-round pair plus register.
// Depends on rc5_pkg for the payload type and rotate functions.
`default_nettype none

module rc5_round
	import rc5_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [31:0] k_enc_a,
	input  wire logic [31:0] k_enc_b,
	input  wire logic [31:0] k_dec_a,
	input  wire logic [31:0] k_dec_b,
	input  wire logic        up_vld,
	input  wire pld_t        up_pld,
	output logic             up_rdy,
	output logic             dn_vld,
	output pld_t             dn_pld,
	input  wire logic        dn_rdy
);

	logic  vld_sr;
	pld_t  pld_sr;
	pld_t  nxt;
	logic [31:0] ep, eq, dp, dq;

	always_comb begin
		ep = rotl32(up_pld.a ^ up_pld.b, up_pld.b[4:0]) + k_enc_a;
		eq = rotl32(up_pld.b ^ ep, ep[4:0]) + k_enc_b;
		dq = rotr32(up_pld.b - k_dec_b, up_pld.a[4:0]) ^ up_pld.a;
		dp = rotr32(up_pld.a - k_dec_a, dq[4:0]) ^ dq;
		nxt = up_pld;
		if (up_pld.dec) begin
			nxt.a = dp;
			nxt.b = dq;
		end else begin
			nxt.a = ep;
			nxt.b = eq;
		end
	end

	assign up_rdy = !vld_sr || dn_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sr <= 1'b0;
		end else if (up_rdy) begin
			vld_sr <= up_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (up_rdy && up_vld) begin
			pld_sr <= nxt;
		end
	end

	assign dn_vld = vld_sr;
	assign dn_pld = pld_sr;

endmodule

`default_nettype wire

>>> rtl/core/rc5_keysched.sv
// RC5 key schedule: subkey table and mixed key words as circular shift registers,
// one mix step per cycle. Depends on rc5_pkg for constants and rotate functions.
`default_nettype none

module rc5_keysched
	import rc5_pkg::*;
#(
	parameter int TABLE_WORDS = 2 * RC5_ROUNDS + 2
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   start,
	input  wire logic [RC5_KEY_WORDS-1:0][31:0]         key,
	output logic                                        busy,
	output logic [TABLE_WORDS-1:0][31:0]                subkey
);

	localparam int TOTAL = 3 * TABLE_WORDS;
	localparam int CW    = $clog2(TOTAL);

	logic [TABLE_WORDS-1:0][31:0]   table_q;
	logic [RC5_KEY_WORDS-1:0][31:0] mix_q;
	logic [31:0]                    x_q, y_q;
	logic [CW-1:0]                  cnt_q;
	logic                           busy_q;
	logic [31:0]                    x_n, y_n, xy;

	always_comb begin
		x_n = rotl32(table_q[0] + x_q + y_q, MIX_ROT);
		xy  = x_n + y_q;
		y_n = rotl32(mix_q[0] + xy, xy[4:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_q <= '0;
			mix_q   <= '0;
			x_q     <= '0;
			y_q     <= '0;
			cnt_q   <= '0;
			busy_q  <= 1'b0;
		end else if (start) begin
			for (int k = 0; k < TABLE_WORDS; k++) begin
				table_q[k] <= magic_init(k);
			end
			mix_q  <= key;
			x_q    <= '0;
			y_q    <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			for (int k = 0; k < TABLE_WORDS - 1; k++) begin
				table_q[k] <= table_q[k+1];
			end
			table_q[TABLE_WORDS-1] <= x_n;
			for (int k = 0; k < RC5_KEY_WORDS - 1; k++) begin
				mix_q[k] <= mix_q[k+1];
			end
			mix_q[RC5_KEY_WORDS-1] <= y_n;
			x_q   <= x_n;
			y_q   <= y_n;
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(TOTAL - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy   = busy_q;
	assign subkey = table_q;

endmodule

`default_nettype wire

>>> rtl/core/rc5_block_cipher.sv
// RC5-32/ROUNDS/16 block cipher top level: APB key registers, entry stage,
// ROUNDS round stages, exit stage. Depends on rc5_pkg, rc5_round, rc5_keysched.
//
// Encrypt and decrypt items stream at one 64-bit block per cycle unless out_ready is low
// or a key expansion runs. Stages: one whitening stage, one stage per round,
// one unwhitening/output stage. A key expansion item (mode 2) is taken only once the
// pipeline has drained; it emits a zero result, and the key mix steps then run,
// during which no item is taken.
// Key registers take effect at the next expansion; the subkey table resets to zero.
// Mode 3 gives a zero result and changes nothing.
`default_nettype none
`include "rc5_block_cipher_macros.svh"

module rc5_block_cipher
	import rc5_pkg::*;
#(
	parameter int ROUNDS = RC5_ROUNDS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [1:0]            mode,
	input  wire logic [31:0]           word_a,
	input  wire logic [31:0]           word_b,
	input  wire logic                  block_last,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [31:0]                out_a,
	output logic [31:0]                out_b,
	output logic                       out_last,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [RC5_APB_AW-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	localparam int TW = 2 * ROUNDS + 2;

	logic [RC5_KEY_WORDS-1:0][31:0] key_q;
	logic [TW-1:0][31:0]            subkey;
	logic                           ks_busy;
	logic                           ks_start;
	logic                           pipe_busy;
	logic                           in_xfer;

	logic                           vld_s1;
	pld_t                           pld_s1;
	pld_t                           entry_nxt;
	logic                           vld_so;
	pld_t                           pld_so;
	pld_t                           exit_nxt;

	logic [ROUNDS:0]                ch_vld;
	logic [ROUNDS:0]                ch_rdy;
	pld_t                           ch_pld [ROUNDS+1];

	// APB key registers
	assign pready = 1'b1;
	assign prdata = key_q[paddr[3:2]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			key_q[paddr[3:2]] <= pwdata;
		end
	end

	// input transfer and expansion start
	assign pipe_busy = (|ch_vld) || vld_so;
	assign in_ready  = (!vld_s1 || ch_rdy[0]) && !ks_busy
		&& ((mode != MODE_EXPAND) || !pipe_busy);
	assign in_xfer   = in_valid && in_ready;
	assign ks_start  = in_xfer && (mode == MODE_EXPAND);

	rc5_keysched #(
		.TABLE_WORDS(TW)
	) u_keysched (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ks_start),
		.key    (key_q),
		.busy   (ks_busy),
		.subkey (subkey)
	);

	// entry stage: whitening for encrypt
	always_comb begin
		entry_nxt.last = block_last;
		entry_nxt.dec  = (mode == MODE_DEC);
		entry_nxt.zero = (mode != MODE_ENC) && (mode != MODE_DEC);
		case (mode)
			MODE_ENC: begin
				entry_nxt.a = word_a + subkey[0];
				entry_nxt.b = word_b + subkey[1];
			end
			MODE_DEC: begin
				entry_nxt.a = word_a;
				entry_nxt.b = word_b;
			end
			default: begin
				entry_nxt.a = '0;
				entry_nxt.b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!vld_s1 || ch_rdy[0]) begin
			vld_s1 <= in_xfer;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pld_s1 <= entry_nxt;
		end
	end

	assign ch_vld[0] = vld_s1;
	assign ch_pld[0] = pld_s1;

	// round stages
	for (genvar i = 1; i <= ROUNDS; i++) begin : g_round
		rc5_round u_round (
			.clk     (clk),
			.arst_n  (arst_n),
			.k_enc_a (subkey[2*i]),
			.k_enc_b (subkey[2*i+1]),
			.k_dec_a (subkey[2*(ROUNDS+1-i)]),
			.k_dec_b (subkey[2*(ROUNDS+1-i)+1]),
			.up_vld  (ch_vld[i-1]),
			.up_pld  (ch_pld[i-1]),
			.up_rdy  (ch_rdy[i-1]),
			.dn_vld  (ch_vld[i]),
			.dn_pld  (ch_pld[i]),
			.dn_rdy  (ch_rdy[i])
		);
	end

	// exit stage: unwhitening for decrypt, zero for expansion and unused modes
	assign ch_rdy[ROUNDS] = !vld_so || out_ready;

	always_comb begin
		exit_nxt = ch_pld[ROUNDS];
		if (ch_pld[ROUNDS].zero) begin
			exit_nxt.a = '0;
			exit_nxt.b = '0;
		end else if (ch_pld[ROUNDS].dec) begin
			exit_nxt.a = ch_pld[ROUNDS].a - subkey[0];
			exit_nxt.b = ch_pld[ROUNDS].b - subkey[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_so <= 1'b0;
		end else if (ch_rdy[ROUNDS]) begin
			vld_so <= ch_vld[ROUNDS];
		end
	end

	always_ff @(posedge clk) begin
		if (ch_vld[ROUNDS] && ch_rdy[ROUNDS]) begin
			pld_so <= exit_nxt;
		end
	end

	assign out_valid = vld_so;
	assign out_a     = pld_so.a;
	assign out_b     = pld_so.b;
	assign out_last  = pld_so.last;

	`RC5_ASSERT_IMP(a_no_xfer_in_expand, ks_busy, !in_ready, "transfer taken during key expansion")
	`RC5_ASSERT_IMP(a_expand_on_empty, ks_start, !pipe_busy, "key expansion started with items in flight")
	`RC5_ASSERT_NXT(a_expand_runs, ks_start, ks_busy, "key expansion did not start")

endmodule

`default_nettype wire

>>> bench/testbench.sv
// Self-checking testbench for rc5_block_cipher: encrypt, decrypt, key expansion and
// unused-mode transfers under random stalls, checked against a built-in predictor.
// Depends on rc5_pkg and the rc5_block_cipher RTL.
module testbench;
	import rc5_pkg::*;

	typedef logic [31:0] word_t;

	typedef struct packed {
		word_t a;
		word_t b;
		logic  last;
	} block_out_t;

	localparam int         TABLE_WORDS  = 2 * RC5_ROUNDS + 2;
	localparam int         MIX_PASSES   = 3;
	localparam logic [1:0] MODE_NONE    = 2'd3;
	localparam int         KEY_REG_0    = 0;
	localparam int         KEY_REG_1    = 1;
	localparam int         KEY_REG_2    = 2;
	localparam int         KEY_REG_3    = 3;
	localparam int         REG_STRIDE   = 4;
	localparam int         DRAIN_CYCLES = MIX_PASSES * TABLE_WORDS + RC5_ROUNDS + 16;
	localparam int         HOLD_CYCLES  = 300;
	localparam int         LIMIT_CYCLES = 500000;
	localparam word_t      ALL_ONES     = 32'hFFFF_FFFF;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [1:0]            mode;
	word_t                 word_a;
	word_t                 word_b;
	logic                  block_last;
	logic                  out_valid;
	logic                  out_ready;
	word_t                 out_a;
	word_t                 out_b;
	logic                  out_last;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [RC5_APB_AW-1:0] paddr;
	word_t                 pwdata;
	word_t                 prdata;
	logic                  pready;

	word_t      model_key [RC5_KEY_WORDS];
	word_t      model_subkeys [TABLE_WORDS];
	word_t      model_mix [RC5_KEY_WORDS];
	block_out_t pending_results [$];
	block_out_t head_result;
	int         send_idle_pct;
	int         recv_idle_pct;
	int         hold_cycles;
	int         error_count;
	int         cycle_count;

	rc5_block_cipher dut (.*);

	always #10 clk = ~clk;

	function automatic word_t rotl_word(input word_t v, input word_t n);
		int s;
		s = n[4:0];
		if (s == 0)
			return v;
		return (v << s) | (v >> (32 - s));
	endfunction

	function automatic word_t rotr_word(input word_t v, input word_t n);
		int s;
		s = n[4:0];
		if (s == 0)
			return v;
		return (v >> s) | (v << (32 - s));
	endfunction

	function automatic block_out_t predict_block(input logic [1:0] op, input word_t a,
			input word_t b, input logic fin);
		block_out_t res;
		word_t      p;
		word_t      q;
		word_t      x;
		word_t      y;
		int         si;
		int         li;
		res.a = '0;
		res.b = '0;
		res.last = fin;
		case (op)
			MODE_ENC: begin
				p = a + model_subkeys[0];
				q = b + model_subkeys[1];
				for (int r = 1; r <= RC5_ROUNDS; r++) begin
					p = rotl_word(p ^ q, q) + model_subkeys[2 * r];
					q = rotl_word(q ^ p, p) + model_subkeys[2 * r + 1];
				end
				res.a = p;
				res.b = q;
			end
			MODE_DEC: begin
				p = a;
				q = b;
				for (int r = RC5_ROUNDS; r >= 1; r--) begin
					q = rotr_word(q - model_subkeys[2 * r + 1], p) ^ p;
					p = rotr_word(p - model_subkeys[2 * r], q) ^ q;
				end
				res.a = p - model_subkeys[0];
				res.b = q - model_subkeys[1];
			end
			MODE_EXPAND: begin
				for (int k = 0; k < RC5_KEY_WORDS; k++)
					model_mix[k] = model_key[k];
				model_subkeys[0] = MAGIC_P;
				for (int k = 1; k < TABLE_WORDS; k++)
					model_subkeys[k] = model_subkeys[k - 1] + MAGIC_Q;
				x = '0;
				y = '0;
				si = 0;
				li = 0;
				for (int k = 0; k < MIX_PASSES * TABLE_WORDS; k++) begin
					x = rotl_word(model_subkeys[si] + x + y, word_t'(MIX_ROT));
					model_subkeys[si] = x;
					si = (si + 1) % TABLE_WORDS;
					y = rotl_word(model_mix[li] + x + y, x + y);
					model_mix[li] = y;
					li = (li + 1) % RC5_KEY_WORDS;
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic word_t rand_word();
		case ($urandom_range(9))
			0: return '0;
			1: return ALL_ONES;
			default: return $urandom;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input word_t got, input word_t want);
		$display("%0t mismatch %s: got %h want %h", $time, what, got, want);
		error_count++;
	endtask

	task automatic send_block(input logic [1:0] op, input word_t a, input word_t b,
			input logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= op;
		word_a <= a;
		word_b <= b;
		block_last <= fin;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(predict_block(op, a, b, fin));
		@(negedge clk);
	endtask

	task automatic send_random_block();
		logic [1:0] op;
		int         pick;
		pick = $urandom_range(99);
		if (pick < 42)
			op = MODE_ENC;
		else if (pick < 84)
			op = MODE_DEC;
		else if (pick < 92)
			op = MODE_EXPAND;
		else
			op = MODE_NONE;
		send_block(op, rand_word(), rand_word(), 1'($urandom_range(1)));
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_key(input int idx, input word_t value);
		word_t readback;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= RC5_APB_AW'(idx * REG_STRIDE);
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		model_key[idx] = value;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		readback = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (readback !== value)
			report_mismatch("key register readback", readback, value);
	endtask

	task automatic load_key(input word_t w0, input word_t w1, input word_t w2, input word_t w3);
		write_key(KEY_REG_0, w0);
		write_key(KEY_REG_1, w1);
		write_key(KEY_REG_2, w2);
		write_key(KEY_REG_3, w3);
	endtask

	task automatic test_cleared_table();
		send_block(MODE_ENC, '0, '0, 1'b0);
		send_block(MODE_ENC, ALL_ONES, ALL_ONES, 1'b1);
		send_block(MODE_DEC, '0, '0, 1'b1);
		send_block(MODE_DEC, ALL_ONES, ALL_ONES, 1'b0);
		send_block(MODE_NONE, ALL_ONES, ALL_ONES, 1'b1);
	endtask

	task automatic test_key_write_latency();
		wait_idle();
		load_key(32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210);
		send_block(MODE_ENC, 32'h0000_0001, 32'h8000_0000, 1'b0);
		send_block(MODE_EXPAND, ALL_ONES, ALL_ONES, 1'b1);
		send_block(MODE_ENC, '0, '0, 1'b0);
		send_block(MODE_DEC, '0, '0, 1'b1);
		send_block(MODE_NONE, '0, '0, 1'b0);
		send_block(MODE_ENC, 32'hDEAD_BEEF, 32'h0BAD_F00D, 1'b1);
	endtask

	task automatic test_extreme_keys();
		wait_idle();
		load_key(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
		send_block(MODE_ENC, '0, ALL_ONES, 1'b1);
		send_block(MODE_EXPAND, '0, '0, 1'b0);
		send_block(MODE_ENC, ALL_ONES, '0, 1'b0);
		send_block(MODE_DEC, '0, ALL_ONES, 1'b1);
		wait_idle();
		load_key('0, '0, '0, '0);
		send_block(MODE_EXPAND, ALL_ONES, '0, 1'b1);
		send_block(MODE_ENC, '0, '0, 1'b0);
		send_block(MODE_DEC, ALL_ONES, ALL_ONES, 1'b1);
	endtask

	task automatic test_output_stall();
		in_valid <= 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		@(posedge clk);
		hold_cycles = HOLD_CYCLES;
		@(negedge clk);
		repeat (40) send_random_block();
	endtask

	task automatic test_random_traffic();
		for (int s = 0; s < 3; s++) begin
			case (s)
				0: begin
					send_idle_pct = 16;
					recv_idle_pct = 62;
				end
				1: begin
					send_idle_pct = 62;
					recv_idle_pct = 16;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int k = 0; k < 5; k++) begin
				wait_idle();
				case (k)
					0: load_key('0, '0, '0, '0);
					1: load_key(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
					default: load_key($urandom, $urandom, $urandom, $urandom);
				endcase
				send_block(MODE_EXPAND, rand_word(), rand_word(), 1'($urandom_range(1)));
				repeat (55) send_random_block();
			end
		end
	endtask

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing pending", out_a, '0);
			end else begin
				head_result = pending_results.pop_front();
				if (out_a !== head_result.a)
					report_mismatch("out_a", out_a, head_result.a);
				if (out_b !== head_result.b)
					report_mismatch("out_b", out_b, head_result.b);
				if (out_last !== head_result.last)
					report_mismatch("out_last", word_t'(out_last), word_t'(head_result.last));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("** rc5_block_cipher: FAILED **");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_ENC;
		word_a = '0;
		word_b = '0;
		block_last = 1'b0;
		out_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		send_idle_pct = 16;
		recv_idle_pct = 62;
		hold_cycles = 0;
		error_count = 0;
		cycle_count = 0;
		for (int k = 0; k < RC5_KEY_WORDS; k++) begin
			model_key[k] = '0;
			model_mix[k] = '0;
		end
		for (int k = 0; k < TABLE_WORDS; k++)
			model_subkeys[k] = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_cleared_table();
		test_key_write_latency();
		test_extreme_keys();
		test_output_stall();
		test_random_traffic();
		wait_idle();
		if (error_count == 0)
			$display("** rc5_block_cipher: PASSED **");
		else
			$display("** rc5_block_cipher: FAILED **");
		$finish;
	end

endmodule

>>> rc5_block_cipher.f
+incdir+rtl/core
rtl/core/rc5_pkg.sv
rtl/core/rc5_round.sv
rtl/core/rc5_keysched.sv
rtl/core/rc5_block_cipher.sv
bench/testbench.sv
